FILE: src/e2c_pkg.sv
// Shared constants, types and the cumulative month table for the epoch-to-calendar block.
`timescale 1ns / 1ps

package e2c_pkg;

  // Width of the seconds count taken from the input.
  localparam int unsigned EPOCH_BITS = 34;
  // One day is more than 2^16 seconds, so the day count fits in EPOCH_BITS - 16 bits.
  localparam int unsigned DAYS_W     = EPOCH_BITS - 16;
  localparam int unsigned TOD_W      = 17;   // seconds within a day
  localparam int unsigned MTOT_W     = 11;   // minutes within a day

  localparam logic [TOD_W-1:0]  SECS_PER_DAY  = 17'd86400;
  localparam logic [5:0]        SECS_PER_MIN  = 6'd60;
  localparam logic [2:0]        DAYS_PER_WEEK = 3'd7;

  // Constant divisions use a rounded-up reciprocal: q = (x * M) >> S, with
  // M = ceil(2^S / d) and S picked so that x * (M * d - 2^S) < 2^S for every x.
  // Seconds / 86400 = (seconds >> 7) / 675.
  localparam int unsigned DAY_POW2 = 7;
  localparam int unsigned DAY_X_W  = EPOCH_BITS - DAY_POW2;
  localparam int unsigned DAY_SH   = EPOCH_BITS + 3;
  localparam int unsigned DAY_M_W  = DAY_SH - 9;
  localparam int unsigned DAY_P_W  = DAY_X_W + DAY_M_W;
  localparam logic [DAY_M_W-1:0] DAY_RECIP =
    DAY_M_W'(((64'd1 << DAY_SH) + 64'd674) / 64'd675);

  // x / 60 = (x >> 2) / 15 for x below 2^17; serves both seconds and minutes.
  localparam int unsigned D60_POW2 = 2;
  localparam int unsigned D60_X_W  = TOD_W - D60_POW2;
  localparam int unsigned D60_SH   = D60_X_W + 4;
  localparam int unsigned D60_M_W  = D60_SH - 3;
  localparam int unsigned D60_P_W  = D60_X_W + D60_M_W;
  localparam logic [D60_M_W-1:0] D60_RECIP =
    D60_M_W'(((64'd1 << D60_SH) + 64'd14) / 64'd15);

  // Day count / 7 for the weekday.
  localparam int unsigned WEEK_SH  = DAYS_W + 3;
  localparam int unsigned WEEK_M_W = DAYS_W + 1;
  localparam int unsigned WEEK_P_W = DAYS_W + WEEK_M_W;
  localparam logic [WEEK_M_W-1:0] WEEK_RECIP =
    WEEK_M_W'(((64'd1 << WEEK_SH) + 64'd6) / 64'd7);

  localparam logic [9:0]        FIRST_YEAR_OFS    = 10'd70;   // 1970 - 1900
  localparam logic [8:0]        FIRST_YEAR_MOD400 = 9'd370;   // 1970 mod 400
  localparam logic [8:0]        LAST_MOD400       = 9'd399;
  localparam logic [8:0]        DAYS_LEAP_YEAR    = 9'd366;
  localparam logic [8:0]        DAYS_COMMON_YEAR  = 9'd365;
  localparam logic [DAYS_W-1:0] EPOCH_WEEKDAY     = DAYS_W'(4);
  localparam logic [DAYS_W-1:0] FEB28_DAY         = DAYS_W'(58);
  localparam logic [DAYS_W-1:0] FEB29_DAY         = DAYS_W'(59);
  localparam logic [3:0]        LAST_MONTH        = 4'd11;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_SEC,
    DIV_MIN,
    DIV_WDAY
  } div_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY_Q,
    S_DAY_R,
    S_SEC_Q,
    S_SEC_R,
    S_MIN_Q,
    S_MIN_R,
    S_WDAY_Q,
    S_WDAY_R,
    S_YEAR,
    S_ADJ,
    S_MONTH,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    load_in;
    logic    div_quo;
    logic    div_rem;
    div_op_e div_op;
    logic    year_step;
    logic    adj;
    logic    mon_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic mon_done;
  } status_t;

  // Days before the first of each month in a common year.
  function automatic logic [8:0] cum_days(input logic [3:0] mon);
    logic [8:0] r;
    case (mon)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/epoch_to_calendar_date.sv
// Top level: unsigned epoch seconds to UTC second, minute, hour, weekday and calendar date.
// Sequence: after request acceptance the constant divisions run, then the year walk and the
//   downward month search, one year and one month per cycle, until out_valid_o.
// Throughput: one request at a time; the next is taken the cycle after the result is registered,
//   while that result may still wait in the output register.
// Reset: rst_ni asynchronous active low clears the controller and the output valid flag.
`timescale 1ns / 1ps

module epoch_to_calendar_date (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [e2c_pkg::EPOCH_BITS-1:0] epoch_seconds_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [5:0]                    second_o,
  output logic [5:0]                    minute_o,
  output logic [4:0]                    hour_o,
  output logic [2:0]                    weekday_o,
  output logic [9:0]                    year_since_1900_o,
  output logic [8:0]                    day_of_year_o,
  output logic [3:0]                    month_o,
  output logic [4:0]                    day_of_month_o
);
  import e2c_pkg::*;

  // Controller and datapath talk only through these two bundles.
  cmd_t    cmd;
  status_t status;

  // Sequencer: four constant divisions, each a quotient step and a remainder
  // step (seconds by a day, seconds of day by 60, minutes of day by 60, days
  // by 7), then the year walk, the leap-day fixup and the downward month search.
  e2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Datapath: reciprocal-multiply dividers, year counter with a mod-400 count
  // for the Gregorian rule, month table and the output register.
  e2c_dp u_dp (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .epoch_seconds_i   (epoch_seconds_i),
    .second_o          (second_o),
    .minute_o          (minute_o),
    .hour_o            (hour_o),
    .weekday_o         (weekday_o),
    .year_since_1900_o (year_since_1900_o),
    .day_of_year_o     (day_of_year_o),
    .month_o           (month_o),
    .day_of_month_o    (day_of_month_o)
  );

endmodule

FILE: src/e2c_dp.sv
// Datapath: reciprocal constant dividers, year walk, month search and result registers.
`timescale 1ns / 1ps

module e2c_dp (
  input  logic                          clk_i,
  input  e2c_pkg::cmd_t                 cmd_i,
  output e2c_pkg::status_t              status_o,
  input  logic [e2c_pkg::EPOCH_BITS-1:0] epoch_seconds_i,
  output logic [5:0]                    second_o,
  output logic [5:0]                    minute_o,
  output logic [4:0]                    hour_o,
  output logic [2:0]                    weekday_o,
  output logic [9:0]                    year_since_1900_o,
  output logic [8:0]                    day_of_year_o,
  output logic [3:0]                    month_o,
  output logic [4:0]                    day_of_month_o
);
  import e2c_pkg::*;

  // divider
  logic [EPOCH_BITS-1:0] secs_q;
  logic [DAYS_W-1:0]     quo_q;

  // intermediate values
  logic [TOD_W-1:0]      tod_q;
  logic [MTOT_W-1:0]     mtot_q;
  logic [5:0]            sec_q;
  logic [5:0]            min_q;
  logic [4:0]            hour_q;
  logic [2:0]            wday_q;
  logic [DAYS_W-1:0]     days_q;
  logic [9:0]            year_q;
  logic [8:0]            y400_q;
  logic [8:0]            yday_q;
  logic [3:0]            mon_q;
  logic [1:0]            mday_base_q;

  logic [DAY_P_W-1:0]       day_prod;
  logic [D60_X_W-1:0]       d60_x;
  logic [D60_P_W-1:0]       d60_prod;
  logic [DAYS_W-1:0]        wday_dvd;
  logic [WEEK_P_W-1:0]      week_prod;
  logic [DAYS_W-1:0]        quo_n;
  logic [DAYS_W+TOD_W-1:0]  day_back;
  logic [5:0]               m60_back;
  logic [2:0]               week_back;
  logic                     leap;
  logic [8:0]               year_len;
  logic [8:0]               mon_cum;
  logic [8:0]               mday_sum;

  always_comb begin
    wday_dvd = days_q + EPOCH_WEEKDAY;

    // quotient: multiply by the reciprocal, keep the high bits
    day_prod  = {{DAY_M_W{1'b0}}, secs_q[EPOCH_BITS-1:DAY_POW2]} *
                {{DAY_X_W{1'b0}}, DAY_RECIP};
    d60_x     = (cmd_i.div_op == DIV_SEC) ? tod_q[TOD_W-1:D60_POW2] :
                {{(D60_X_W-MTOT_W+D60_POW2){1'b0}}, mtot_q[MTOT_W-1:D60_POW2]};
    d60_prod  = {{D60_M_W{1'b0}}, d60_x} * {{D60_X_W{1'b0}}, D60_RECIP};
    week_prod = {{WEEK_M_W{1'b0}}, wday_dvd} * {{DAYS_W{1'b0}}, WEEK_RECIP};
    case (cmd_i.div_op)
      DIV_DAY:  quo_n = day_prod[DAY_P_W-1:DAY_SH];
      DIV_WDAY: quo_n = {2'b00, week_prod[WEEK_P_W-1:WEEK_SH]};
      default:  quo_n = {{(DAYS_W-MTOT_W){1'b0}}, d60_prod[D60_SH +: MTOT_W]};
    endcase

    // remainder: dividend minus quotient times divisor, only the low bits matter
    day_back  = {{TOD_W{1'b0}}, quo_q} * {{DAYS_W{1'b0}}, SECS_PER_DAY};
    m60_back  = quo_q[5:0] * SECS_PER_MIN;
    week_back = quo_q[2:0] * DAYS_PER_WEEK;

    // 400 is a multiple of 4, so the low bits of the mod-400 count give mod 4
    leap     = (y400_q[1:0] == 2'b00) && !(y400_q inside {9'd100, 9'd200, 9'd300});
    year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;

    mon_cum  = cum_days(mon_q);
    mday_sum = {7'd0, mday_base_q} + days_q[8:0] - mon_cum;

    status_o.year_done = (days_q < {{(DAYS_W-9){1'b0}}, year_len});
    status_o.mon_done  = (mon_q == 4'd0) || (mon_cum <= days_q[8:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      secs_q <= epoch_seconds_i;
      year_q <= FIRST_YEAR_OFS;
      y400_q <= FIRST_YEAR_MOD400;
    end

    if (cmd_i.div_quo) begin
      quo_q <= quo_n;
    end

    if (cmd_i.div_rem) begin
      case (cmd_i.div_op)
        DIV_DAY: begin
          tod_q  <= secs_q[TOD_W-1:0] - day_back[TOD_W-1:0];
          days_q <= quo_q;
        end
        DIV_SEC: begin
          sec_q  <= tod_q[5:0] - m60_back;
          mtot_q <= quo_q[MTOT_W-1:0];
        end
        DIV_MIN: begin
          min_q  <= mtot_q[5:0] - m60_back;
          hour_q <= quo_q[4:0];
        end
        default: begin
          wday_q <= wday_dvd[2:0] - week_back;
        end
      endcase
    end

    if (cmd_i.year_step) begin
      days_q <= days_q - {{(DAYS_W-9){1'b0}}, year_len};
      year_q <= year_q + 10'd1;
      y400_q <= (y400_q == LAST_MOD400) ? 9'd0 : y400_q + 9'd1;
    end

    if (cmd_i.adj) begin
      yday_q <= days_q[8:0];
      mon_q  <= LAST_MONTH;
      // past February 28 in a leap year: Feb 29 is day 29, later days shift by one
      if (leap && (days_q > FEB28_DAY)) begin
        mday_base_q <= (days_q == FEB29_DAY) ? 2'd2 : 2'd1;
        days_q      <= days_q - DAYS_W'(1);
      end else begin
        mday_base_q <= 2'd1;
      end
    end

    if (cmd_i.mon_step) begin
      mon_q <= mon_q - 4'd1;
    end

    if (cmd_i.out_load) begin
      second_o          <= sec_q;
      minute_o          <= min_q;
      hour_o            <= hour_q;
      weekday_o         <= wday_q;
      year_since_1900_o <= year_q;
      day_of_year_o     <= yday_q;
      month_o           <= mon_q;
      day_of_month_o    <= mday_sum[4:0];
    end
  end

endmodule

FILE: src/e2c_ctrl.sv
// Controller: sequences divisions, year walk and month search; owns both handshakes.
`timescale 1ns / 1ps

module e2c_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output e2c_pkg::cmd_t    cmd_o,
  input  e2c_pkg::status_t status_i
);
  import e2c_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.div_op = DIV_DAY;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DAY_Q;
        end
      end
      S_DAY_Q: begin
        cmd_o.div_quo = 1'b1;
        state_d       = S_DAY_R;
      end
      S_DAY_R: begin
        cmd_o.div_rem = 1'b1;
        state_d       = S_SEC_Q;
      end
      S_SEC_Q: begin
        cmd_o.div_quo = 1'b1;
        cmd_o.div_op  = DIV_SEC;
        state_d       = S_SEC_R;
      end
      S_SEC_R: begin
        cmd_o.div_rem = 1'b1;
        cmd_o.div_op  = DIV_SEC;
        state_d       = S_MIN_Q;
      end
      S_MIN_Q: begin
        cmd_o.div_quo = 1'b1;
        cmd_o.div_op  = DIV_MIN;
        state_d       = S_MIN_R;
      end
      S_MIN_R: begin
        cmd_o.div_rem = 1'b1;
        cmd_o.div_op  = DIV_MIN;
        state_d       = S_WDAY_Q;
      end
      S_WDAY_Q: begin
        cmd_o.div_quo = 1'b1;
        cmd_o.div_op  = DIV_WDAY;
        state_d       = S_WDAY_R;
      end
      S_WDAY_R: begin
        cmd_o.div_rem = 1'b1;
        cmd_o.div_op  = DIV_WDAY;
        state_d       = S_YEAR;
      end
      S_YEAR: begin
        if (status_i.year_done) begin
          state_d = S_ADJ;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      S_ADJ: begin
        cmd_o.adj = 1'b1;
        state_d   = S_MONTH;
      end
      S_MONTH: begin
        if (status_i.mon_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.mon_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_in, cmd_o.div_quo, cmd_o.div_rem, cmd_o.year_step,
              cmd_o.adj, cmd_o.mon_step, cmd_o.out_load}))
    else $error("more than one datapath command at once");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DAY_Q))
    else $error("accepted request did not start the day division");

  a_finish_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && slot_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not placed in output register");

  a_year_walk_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_YEAR && !status_i.year_done) |=> (state_q == S_YEAR))
    else $error("year walk left before the remaining days fit in a year");
`endif

endmodule

FILE: bench/tb_epoch_to_calendar_date.sv
// Self-checking testbench for epoch_to_calendar_date: directed and random epoch seconds.
`timescale 1ns / 1ps

module tb_epoch_to_calendar_date;
  import e2c_pkg::EPOCH_BITS;

  // Calendar constants for the expected-date calculation.
  localparam longint unsigned DAY_SECS      = 64'd86400;
  localparam longint unsigned FIRST_YEAR    = 64'd1970;
  localparam longint unsigned YEAR_BASE     = 64'd1900;
  localparam longint unsigned EPOCH_WEEKDAY = 64'd4;      // 1970-01-01 was a Thursday
  localparam longint unsigned FEB28_YDAY    = 64'd58;
  localparam longint unsigned FEB29_YDAY    = 64'd59;
  localparam longint unsigned LAST_YEAR     = 64'd2514;   // last year reachable in 34 bits
  localparam longint unsigned MAX_SECS      = (64'd1 << EPOCH_BITS) - 64'd1;
  localparam int unsigned     N_RANDOM      = 1050;
  localparam int unsigned     DRAIN_EVERY   = 300;        // random requests between drains
  localparam int unsigned     TAIL_CYCLES   = 800;        // wait after the last owed date
  localparam int unsigned     RST_CYCLES    = 9;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [9:0] year_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month;
    logic [4:0] day_of_month;
  } date_t;

  // One pending request; drain_first holds it back until every date has come out.
  typedef struct {
    logic [EPOCH_BITS-1:0] secs;
    bit                    drain_first;
  } request_t;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic [EPOCH_BITS-1:0] epoch_seconds_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic [5:0]            second_o;
  logic [5:0]            minute_o;
  logic [4:0]            hour_o;
  logic [2:0]            weekday_o;
  logic [9:0]            year_since_1900_o;
  logic [8:0]            day_of_year_o;
  logic [3:0]            month_o;
  logic [4:0]            day_of_month_o;

  request_t    request_q[$];     // requests not yet sent
  date_t       pending_dates[$]; // dates owed by the block, oldest first
  int unsigned mismatch_count = 0;

  epoch_to_calendar_date dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .epoch_seconds_i   (epoch_seconds_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .second_o          (second_o),
    .minute_o          (minute_o),
    .hour_o            (hour_o),
    .weekday_o         (weekday_o),
    .year_since_1900_o (year_since_1900_o),
    .day_of_year_o     (day_of_year_o),
    .month_o           (month_o),
    .day_of_month_o    (day_of_month_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Gregorian rule: every 4th year, except centuries not divisible by 400.
  function automatic bit is_leap(longint unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint unsigned year_len(longint unsigned y);
    return is_leap(y) ? 64'd366 : 64'd365;
  endfunction

  // Days before the first of month m in a common year.
  function automatic longint unsigned month_start(int unsigned m);
    case (m)
      0:       return 0;
      1:       return 31;
      2:       return 59;
      3:       return 90;
      4:       return 120;
      5:       return 151;
      6:       return 181;
      7:       return 212;
      8:       return 243;
      9:       return 273;
      10:      return 304;
      default: return 334;
    endcase
  endfunction

  // Seconds from the epoch to 00:00:00 on January 1st of year y.
  function automatic longint unsigned year_start_secs(longint unsigned y);
    longint unsigned d;
    d = 0;
    for (longint unsigned k = FIRST_YEAR; k < y; k++) d += year_len(k);
    return d * DAY_SECS;
  endfunction

  // Expected broken-down UTC date for a seconds count.
  function automatic date_t calendar_of(logic [EPOCH_BITS-1:0] secs);
    longint unsigned tod, days, yr, mday;
    int unsigned     mon;
    date_t           r;
    tod       = secs % DAY_SECS;
    days      = secs / DAY_SECS;
    r.second  = 6'(tod % 60);
    r.minute  = 6'((tod / 60) % 60);
    r.hour    = 5'(tod / 3600);
    r.weekday = 3'((EPOCH_WEEKDAY + days) % 7);
    yr = FIRST_YEAR;
    while (days >= year_len(yr)) begin
      days -= year_len(yr);
      yr++;
    end
    r.day_of_year = 9'(days);
    mday = 1;
    // Leap day maps to Feb 29; later days shift back one to reuse the common table.
    if (is_leap(yr) && days > FEB28_YDAY) begin
      if (days == FEB29_YDAY) mday = 2;
      days--;
    end
    mon = 11;
    while (mon > 0 && month_start(mon) > days) mon--;
    mday += days - month_start(mon);
    r.year_since_1900 = 10'(yr - YEAR_BASE);
    r.month           = 4'(mon);
    r.day_of_month    = 5'(mday);
    return r;
  endfunction

  task automatic add_request(longint unsigned s, bit drain_first);
    request_t rq;
    rq.secs        = (s > MAX_SECS) ? EPOCH_BITS'(MAX_SECS) : EPOCH_BITS'(s);
    rq.drain_first = drain_first;
    request_q.push_back(rq);
  endtask

  task automatic compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: bursts of back-to-back requests separated by random gaps. Valid is
  // decided only when the current request is not held by a stall, so a stalled
  // request keeps its payload.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      // Request taken at this edge: its date is now owed.
      if (in_valid_i) pending_dates.push_back(calendar_of(epoch_seconds_i));
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (request_q.size() == 0 ||
                   (request_q[0].drain_first && pending_dates.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i      <= 1'b1;
        epoch_seconds_i <= request_q[0].secs;
        void'(request_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          // Mostly short gaps; now and then a long one that may outlast a whole conversion.
          gap_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 700)
                                                    : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver stall: a mode picked at random and held for a random span - none, light random,
  // heavy random, or a fixed 3-of-5 duty pattern.
  int unsigned stall_mode  = 0;
  int unsigned mode_left   = 0;
  int unsigned duty_phase  = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(64, 512);
      end else begin
        mode_left <= mode_left - 1;
      end
      duty_phase <= (duty_phase == 4) ? 0 : duty_phase + 1;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 1) == 0);
        2:       out_stall_i <= ($urandom_range(0, 7) != 0);
        default: out_stall_i <= (duty_phase < 3);
      endcase
    end
  end

  // Monitor: every accepted date is checked against the oldest one owed.
  always @(posedge clk_i) begin
    date_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected date: expected none, actual %0d-%0d-%0d", $time,
                 year_since_1900_o, month_o, day_of_month_o);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        compare_field("second",          want.second,          second_o);
        compare_field("minute",          want.minute,          minute_o);
        compare_field("hour",            want.hour,            hour_o);
        compare_field("weekday",         want.weekday,         weekday_o);
        compare_field("year_since_1900", want.year_since_1900, year_since_1900_o);
        compare_field("day_of_year",     want.day_of_year,     day_of_year_o);
        compare_field("month",           want.month,           month_o);
        compare_field("day_of_month",    want.day_of_month,    day_of_month_o);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    longint unsigned y, s;
    int unsigned     pick;

    // Directed: field extremes, leap-day handling and year boundaries.
    add_request(0, 1'b0);
    add_request(DAY_SECS - 1, 1'b0);                               // 23:59:59
    add_request(DAY_SECS, 1'b0);
    add_request(MAX_SECS, 1'b0);                                   // all ones
    add_request(year_start_secs(1972) + FEB28_YDAY * DAY_SECS, 1'b0);
    add_request(year_start_secs(1972) + FEB29_YDAY * DAY_SECS, 1'b0);
    add_request(year_start_secs(1972) + 60 * DAY_SECS, 1'b0);      // Mar 1 after leap day
    add_request(year_start_secs(1973) - 1, 1'b0);                  // leap year's day 365
    add_request(year_start_secs(2000) - 1, 1'b0);
    add_request(year_start_secs(2000) + FEB29_YDAY * DAY_SECS + 43210, 1'b0);
    add_request(year_start_secs(2000) + 60 * DAY_SECS, 1'b0);
    add_request(year_start_secs(2001) - 1, 1'b0);
    add_request(year_start_secs(2001), 1'b0);
    // 2100 is a century without a leap day.
    add_request(year_start_secs(2100) + FEB28_YDAY * DAY_SECS, 1'b0);
    add_request(year_start_secs(2100) + FEB29_YDAY * DAY_SECS, 1'b0);
    add_request(year_start_secs(2400) + FEB29_YDAY * DAY_SECS, 1'b0);
    add_request(year_start_secs(LAST_YEAR) - 1, 1'b0);
    add_request(year_start_secs(LAST_YEAR), 1'b0);
    add_request(64'h7FFF_FFFF, 1'b0);
    add_request(64'hFFFF_FFFF, 1'b0);
    add_request(64'h1_0000_0000, 1'b0);
    add_request(64'h2_AAAA_AAAA, 1'b0);
    add_request(64'h1_5555_5555, 1'b0);

    // Random: full-width and 32-bit values, values near year ends and around the leap day.
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 9);
      y    = $urandom_range(FIRST_YEAR, LAST_YEAR);
      if (pick < 4) begin
        s = {$urandom_range(0, 3), $urandom};
      end else if (pick < 6) begin
        s = $urandom;
      end else if (pick < 8) begin
        // Last or first day of a year.
        s = year_start_secs(y) + $urandom_range(0, DAY_SECS - 1);
        if (y > FIRST_YEAR && $urandom_range(0, 1) == 1) s -= DAY_SECS;
      end else begin
        // Days 57 to 61 of the year (from Feb 27 on), or days 364 and 365.
        s = year_start_secs(y) + $urandom_range(0, DAY_SECS - 1) +
            (($urandom_range(0, 3) == 0) ? $urandom_range(364, 365)
                                         : $urandom_range(57, 61)) * DAY_SECS;
      end
      if (s > MAX_SECS) s = {$urandom_range(0, 3), $urandom};
      add_request(s, (i % DRAIN_EVERY) == 0);
    end

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_valid_i || pending_dates.size() != 0)
      @(posedge clk_i);
    // Allow for any stray extra date.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[epoch_to_calendar_date] OK");
    end else begin
      $display("[epoch_to_calendar_date] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #40ms;
    $display("[epoch_to_calendar_date] ERROR");
    $finish;
  end

endmodule
